// ----- rtl/trd_pkg.sv -----
// Shared types and constants for the tracker record deframer.
// Holds the front-to-back command word, byte codes and field widths.
// No dependencies; every other file imports this package.
package trd_pkg;

  localparam int BYTE_W       = 8;
  localparam int WORD_W       = 32;
  localparam int NUM_WORDS    = 6;
  localparam int PAYLOAD_LEN  = NUM_WORDS * (WORD_W / BYTE_W);  // 24
  localparam int POS_W        = 5;
  localparam int STATION_W    = 3;
  localparam int STEP_W       = 3;
  localparam int OUT_BITS     = STATION_W + NUM_WORDS * WORD_W + 3;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [BYTE_W-1:0] CHR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHR_ONE   = 8'h31;
  localparam logic [BYTE_W-1:0] CHR_FOUR  = 8'h34;
  localparam logic [BYTE_W-1:0] CHR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHR_UP_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CHR_UP_Z  = 8'h5A;
  localparam logic [BYTE_W-1:0] CHR_LO_A  = 8'h61;
  localparam logic [BYTE_W-1:0] CHR_LO_Z  = 8'h7A;

  // Header positions
  localparam logic [STEP_W-1:0] HDR_CR      = 3'd0;
  localparam logic [STEP_W-1:0] HDR_LF      = 3'd1;
  localparam logic [STEP_W-1:0] HDR_ZERO    = 3'd2;
  localparam logic [STEP_W-1:0] HDR_STATION = 3'd3;

  localparam logic [POS_W-1:0] POS_LAST_PAYLOAD = POS_W'(PAYLOAD_LEN - 1);
  localparam logic [POS_W-1:0] POS_STYLUS_SKIP  = POS_W'(PAYLOAD_LEN);

  localparam logic [STATION_W-1:0] STATION_STYLUS = 3'd1;

  // Command handed from the parser to the assembler
  typedef struct packed {
    logic                 wr;        // store data at pos
    logic [POS_W-1:0]     pos;
    logic [BYTE_W-1:0]    data;
    logic                 done;      // record finished, emit a result
    logic [STATION_W-1:0] station;
    logic                 btn_valid;
    logic                 btn_pressed;
    logic                 lost;
  } trd_cmd_t;

endpackage

// ----- rtl/tracker_record_deframer_unit.sv -----
// Top level of the tracker record deframer: parser, command queue, assembler.
// Depends on trd_pkg, trd_front, trd_queue and trd_back.
//
//   channel   direction  signals                          payload
//   s_axis    in         tvalid tready tdata[7:0]         rx_byte
//   m_axis    out        tvalid tready tdata[199:0]       one finished record
//   cfg       in         cfg_valid cfg_ready cfg_data     stylus_enabled
//
// One byte is taken every cycle while the two-entry command queue has room.
// A finished record is written into the command queue when its last byte is
// transferred; the output register is then loaded from the queue head once
// any result that it still holds has been taken.
// Reset clears parser state, the queue and the output valid; stylus_enabled
// resets to 1. A stalled output holds only the assembler on a record end;
// payload bytes of the next record keep flowing until the queue fills.
module tracker_record_deframer_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] station, [34:3] pos_x, [66:35] pos_y, [98:67] pos_z,
  // [130:99] angle_azimuth, [162:131] angle_elevation, [194:163] angle_roll,
  // [195] button_valid, [196] button_pressed, [197] lost_sync, [199:198] zero
  output logic [trd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data        // stylus_enabled
);
  import trd_pkg::*;

  logic     stylus_enabled;
  logic     cmd_push;
  trd_cmd_t cmd_in;
  logic     cmd_full;
  logic     cmd_pop;
  logic     cmd_nonempty;
  trd_cmd_t cmd_head;

  // register write is always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stylus_enabled <= 1'b1;
    end else if (cfg_valid) begin
      stylus_enabled <= cfg_data;
    end
  end

  // classify bytes and track header / payload position
  trd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .in_byte        (s_axis_tdata),
    .stylus_enabled (stylus_enabled),
    .cmd_push       (cmd_push),
    .cmd            (cmd_in),
    .cmd_full       (cmd_full)
  );

  // decouple parser from result stalls
  trd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .nonempty (cmd_nonempty),
    .head     (cmd_head)
  );

  // gather words and present finished records
  trd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_nonempty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// ----- rtl/trd_front.sv -----
// Byte parser: header match with resync hunt, payload counting, stylus bytes.
// Emits one trd_cmd_t per payload byte and per stylus button byte; the last one marks the record end.
// Depends on trd_pkg.
module trd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                stylus_enabled,
  output logic                cmd_push,
  output trd_pkg::trd_cmd_t   cmd,
  input  logic                cmd_full
);
  import trd_pkg::*;

  logic                 in_payload, in_payload_next;
  logic                 hunting, hunting_next;
  logic [STEP_W-1:0]    match_step, match_step_next;
  logic [POS_W-1:0]     payload_count, payload_count_next;
  logic [STATION_W-1:0] station_reg, station_reg_next;
  logic                 resync_seen, resync_seen_next;
  logic                 take;
  logic                 hdr_ok;
  logic                 is_filler;

  assign in_ready = !cmd_full;
  assign take     = in_valid && in_ready;

  assign is_filler = (in_byte == CHR_SPACE) ||
                     (in_byte >= CHR_UP_A && in_byte <= CHR_UP_Z) ||
                     (in_byte >= CHR_LO_A && in_byte <= CHR_LO_Z);

  always_comb begin
    unique case (match_step)
      HDR_CR:      hdr_ok = (in_byte == CHR_CR);
      HDR_LF:      hdr_ok = (in_byte == CHR_LF);
      HDR_ZERO:    hdr_ok = (in_byte == CHR_ZERO);
      HDR_STATION: hdr_ok = (in_byte >= CHR_ONE) && (in_byte <= CHR_FOUR);
      default:     hdr_ok = is_filler;
    endcase
  end

  always_comb begin
    in_payload_next    = in_payload;
    hunting_next       = hunting;
    match_step_next    = match_step;
    payload_count_next = payload_count;
    station_reg_next   = station_reg;
    resync_seen_next   = resync_seen;
    cmd_push           = 1'b0;
    cmd.wr             = 1'b0;
    cmd.pos            = payload_count;
    cmd.data           = in_byte;
    cmd.done           = 1'b0;
    cmd.station        = station_reg;
    cmd.btn_valid      = 1'b0;
    cmd.btn_pressed    = 1'b0;
    cmd.lost           = resync_seen;

    if (take) begin
      if (in_payload) begin
        if (payload_count < POS_STYLUS_SKIP) begin
          cmd_push           = 1'b1;
          cmd.wr             = 1'b1;
          payload_count_next = payload_count + POS_W'(1);
          if (payload_count == POS_LAST_PAYLOAD &&
              !(station_reg == STATION_STYLUS && stylus_enabled)) begin
            cmd.done = 1'b1;
          end
        end else if (payload_count == POS_STYLUS_SKIP) begin
          // first stylus byte carries nothing we report
          payload_count_next = payload_count + POS_W'(1);
        end else begin
          cmd_push        = 1'b1;
          cmd.done        = 1'b1;
          cmd.btn_valid   = 1'b1;
          cmd.btn_pressed = (in_byte == CHR_ONE);
        end
        if (cmd.done) begin
          in_payload_next    = 1'b0;
          payload_count_next = '0;
          hunting_next       = 1'b0;
          match_step_next    = HDR_CR;
          resync_seen_next   = 1'b0;
        end
      end else if (hdr_ok) begin
        if (match_step == HDR_STATION) begin
          station_reg_next = in_byte[STATION_W-1:0];
        end
        if (match_step > HDR_STATION) begin
          in_payload_next    = 1'b1;
          payload_count_next = '0;
          match_step_next    = HDR_CR;
        end else begin
          match_step_next = match_step + STEP_W'(1);
        end
      end else if (!hunting) begin
        hunting_next     = 1'b1;
        resync_seen_next = 1'b1;
        match_step_next  = HDR_CR;
      end else begin
        match_step_next = (in_byte == CHR_CR) ? HDR_LF : HDR_CR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload    <= 1'b0;
      hunting       <= 1'b0;
      match_step    <= HDR_CR;
      payload_count <= '0;
      station_reg   <= '0;
      resync_seen   <= 1'b0;
    end else begin
      in_payload    <= in_payload_next;
      hunting       <= hunting_next;
      match_step    <= match_step_next;
      payload_count <= payload_count_next;
      station_reg   <= station_reg_next;
      resync_seen   <= resync_seen_next;
    end
  end

endmodule

// ----- rtl/trd_queue.sv -----
// Two-entry command queue between the parser and the assembler.
// Depends on trd_pkg for the command type.
module trd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  trd_pkg::trd_cmd_t   push_cmd,
  output logic                full,
  input  logic                pop,
  output logic                nonempty,
  output trd_pkg::trd_cmd_t   head
);
  import trd_pkg::*;

  trd_cmd_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/trd_back.sv -----
// Record assembler: stores payload bytes and loads the result register.
// Depends on trd_pkg.
module trd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  trd_pkg::trd_cmd_t             cmd,
  output logic                          cmd_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [trd_pkg::OUT_TDATA_W-1:0] out_data
);
  import trd_pkg::*;

  logic [BYTE_W-1:0] asm_bytes      [PAYLOAD_LEN];
  logic [BYTE_W-1:0] asm_bytes_next [PAYLOAD_LEN];
  logic [NUM_WORDS*WORD_W-1:0] words_flat;

  // a finished record waits only while the result register is still held
  assign cmd_pop = cmd_valid && (!cmd.done || !out_valid || out_ready);

  always_comb begin
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      asm_bytes_next[i] = asm_bytes[i];
      if (cmd.wr && cmd.pos == POS_W'(i)) begin
        asm_bytes_next[i] = cmd.data;
      end
      words_flat[i*BYTE_W +: BYTE_W] = asm_bytes_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      asm_bytes <= asm_bytes_next;
    end
    if (cmd_pop && cmd.done) begin
      out_data <= {(OUT_TDATA_W - OUT_BITS)'(0), cmd.lost, cmd.btn_pressed,
                   cmd.btn_valid, words_flat, cmd.station};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_pop && cmd.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for tracker_record_deframer_unit: byte stream in, records out.
// Depends on trd_pkg and the deframer RTL; predicts every record and compares fields.
module tb_top;
  import trd_pkg::*;

  // Unpacked view of one finished record, station in the lowest bits
  typedef struct packed {
    logic        lost;
    logic        pressed;
    logic        bvalid;
    logic [31:0] roll;
    logic [31:0] elev;
    logic [31:0] azim;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
    logic [2:0]  station;
  } record_t;

  localparam logic [STEP_W-1:0] HDR_FILLER = 3'd4;
  localparam int PAY_RANDOM  = 0;
  localparam int PAY_ZEROS   = 1;
  localparam int PAY_ONES    = 2;
  localparam int SETTLE      = 8;       // cycles to let the pipeline go quiet
  localparam int CYCLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;

  // Deframer copy kept by the bench
  logic             hunting  = 1'b0;
  logic [STEP_W-1:0] hdr_step = '0;
  logic             in_rec   = 1'b0;
  logic [POS_W-1:0] pay_cnt  = '0;
  logic [2:0]       stn_reg  = '0;
  logic             resync   = 1'b0;
  logic [31:0]      words [NUM_WORDS];
  logic             stylus_on = 1'b1;

  record_t pending_records [$];
  record_t got_rec, want_rec;

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int hold_cycles   = 0;
  int cycles        = 0;
  int errors        = 0;
  int bytes_sent    = 0;
  int rec_count     = 0;
  int lost_count    = 0;
  int btn_count     = 0;
  int pressed_count = 0;

  tracker_record_deframer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d records outstanding", $time, pending_records.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic bit header_byte_ok(input logic [STEP_W-1:0] step, input logic [7:0] b);
    case (step)
      HDR_CR:      return b == CHR_CR;
      HDR_LF:      return b == CHR_LF;
      HDR_ZERO:    return b == CHR_ZERO;
      HDR_STATION: return b >= CHR_ONE && b <= CHR_FOUR;
      default:     return b == CHR_SPACE || (b >= CHR_UP_A && b <= CHR_UP_Z) ||
                          (b >= CHR_LO_A && b <= CHR_LO_Z);
    endcase
  endfunction

  // Build the record and return to strict header matching
  function automatic record_t close_record(input logic bvalid, input logic pressed);
    record_t r;
    r.station = stn_reg;
    r.x       = words[0];
    r.y       = words[1];
    r.z       = words[2];
    r.azim    = words[3];
    r.elev    = words[4];
    r.roll    = words[5];
    r.bvalid  = bvalid;
    r.pressed = pressed;
    r.lost    = resync;
    in_rec   = 1'b0;
    pay_cnt  = '0;
    hunting  = 1'b0;
    hdr_step = HDR_CR;
    resync   = 1'b0;
    return r;
  endfunction

  // Advance the expected deframer by one byte; 1 when a record finishes
  function automatic bit deframe_byte(input logic [7:0] b, output record_t r);
    int n;
    logic [STEP_W-1:0] step;
    r = '0;
    n = int'(pay_cnt);
    if (in_rec) begin
      if (n < PAYLOAD_LEN) begin
        words[n >> 2][(n & 3) * 8 +: 8] = b;
        pay_cnt = POS_W'(n + 1);
        if (n + 1 == PAYLOAD_LEN && !(stn_reg == STATION_STYLUS && stylus_on)) begin
          r = close_record(1'b0, 1'b0);
          return 1'b1;
        end
        return 1'b0;
      end
      if (n == PAYLOAD_LEN) begin
        pay_cnt = POS_W'(n + 1);   // first stylus byte carries nothing
        return 1'b0;
      end
      r = close_record(1'b1, b == CHR_ONE);
      return 1'b1;
    end
    step = (hdr_step > HDR_FILLER) ? HDR_CR : hdr_step;
    if (header_byte_ok(step, b)) begin
      if (step == HDR_STATION) stn_reg = 3'(b - CHR_ZERO);
      if (step == HDR_FILLER) begin
        in_rec   = 1'b1;
        pay_cnt  = '0;
        hdr_step = HDR_CR;
      end else begin
        hdr_step = step + 3'd1;
      end
    end else if (!hunting) begin
      // strict mismatch: drop the byte and start hunting
      hunting  = 1'b1;
      resync   = 1'b1;
      hdr_step = HDR_CR;
    end else begin
      // hunt mismatch: a CR counts as the first header byte
      hdr_step = (b == CHR_CR) ? HDR_LF : HDR_CR;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Record checker: compare every output transfer with the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_rec = record_t'(m_axis_tdata[OUT_BITS-1:0]);
      if (pending_records.size() == 0) begin
        errors++;
        $display("%0t: unexpected record, expected none, actual %h", $time, got_rec);
      end else begin
        want_rec = pending_records.pop_front();
        check_field("station", 32'(want_rec.station), 32'(got_rec.station));
        check_field("pos_x", want_rec.x, got_rec.x);
        check_field("pos_y", want_rec.y, got_rec.y);
        check_field("pos_z", want_rec.z, got_rec.z);
        check_field("angle_azimuth", want_rec.azim, got_rec.azim);
        check_field("angle_elevation", want_rec.elev, got_rec.elev);
        check_field("angle_roll", want_rec.roll, got_rec.roll);
        check_field("button_valid", 32'(want_rec.bvalid), 32'(got_rec.bvalid));
        check_field("button_pressed", 32'(want_rec.pressed), 32'(got_rec.pressed));
        check_field("lost_sync", 32'(want_rec.lost), 32'(got_rec.lost));
        check_field("pad", '0, 32'(m_axis_tdata[OUT_TDATA_W-1:OUT_BITS]));
      end
      rec_count++;
      lost_count    += int'(got_rec.lost);
      btn_count     += int'(got_rec.bvalid);
      pressed_count += int'(got_rec.pressed);
    end
  end

  // Receiver: hold off for a counted stretch when asked, else stall at random
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers (all entered and left at a falling edge)
  // ---------------------------------------------------------------------------

  // Offer one byte, wait for its transfer, then predict it
  task automatic send_byte(input logic [7:0] b);
    record_t r;
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
    if (deframe_byte(b, r)) pending_records.push_back(r);
    @(negedge clk);
  endtask

  // Drop valid, wait for every expected record, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Call only after drain(): the block must be idle
  task automatic write_stylus(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    stylus_on = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] header_char(input int pos, input logic [2:0] stn,
                                             input logic [7:0] fill);
    case (pos)
      0:       return CHR_CR;
      1:       return CHR_LF;
      2:       return CHR_ZERO;
      3:       return CHR_ZERO + 8'(stn);
      default: return fill;
    endcase
  endfunction

  function automatic logic [7:0] payload_char(input int pmode);
    case (pmode)
      PAY_ZEROS: return 8'h00;
      PAY_ONES:  return 8'hFF;
      default:   return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_filler();
    int r;
    r = $urandom_range(52);
    if (r == 0) return CHR_SPACE;
    if (r <= 26) return CHR_UP_A + 8'(r - 1);
    return CHR_LO_A + 8'(r - 27);
  endfunction

  // Bytes that tend to poke the header matcher
  function automatic logic [7:0] noise_char();
    case ($urandom_range(4))
      0:       return CHR_CR;
      1:       return CHR_LF;
      2:       return CHR_ZERO;
      3:       return CHR_ZERO + 8'($urandom_range(9));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_header(input logic [2:0] stn, input logic [7:0] fill);
    for (int i = 0; i < 5; i++) send_byte(header_char(i, stn, fill));
  endtask

  task automatic send_payload(input int n, input int pmode);
    repeat (n) send_byte(payload_char(pmode));
  endtask

  task automatic send_bytes(input logic [7:0] seq [$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Whole record; stylus bytes follow when the current setting calls for them
  task automatic send_record(input logic [2:0] stn, input logic [7:0] fill,
                             input int pmode, input logic [7:0] btn);
    send_header(stn, fill);
    send_payload(PAYLOAD_LEN, pmode);
    if (stn == STATION_STYLUS && stylus_on) begin
      send_byte(8'($urandom));
      send_byte(btn);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Clean records: every station, filler extremes, payload extremes, both buttons
  task automatic test_clean_records();
    send_record(3'd1, CHR_SPACE, PAY_ZEROS, CHR_ONE);
    send_record(3'd1, CHR_UP_Z, PAY_ONES, CHR_ZERO);
    send_record(3'd2, CHR_UP_A, PAY_RANDOM, CHR_ONE);
    send_record(3'd3, CHR_LO_A, PAY_RANDOM, CHR_ONE);
    send_record(3'd4, CHR_LO_Z, PAY_ONES, CHR_ONE);
  endtask

  // Header mismatches: strict drop, hunt restart with and without CR
  task automatic test_header_resync();
    send_byte(8'hFF);                          // strict mismatch on the first byte
    send_record(3'd2, CHR_SPACE, PAY_RANDOM, CHR_ONE);
    send_record(3'd3, CHR_LO_A + 8'd16, PAY_RANDOM, CHR_ONE);  // lost_sync cleared
    // bad station, station zero, filler just outside each letter range
    send_bytes('{CHR_CR, CHR_LF, CHR_ZERO, CHR_FOUR + 8'd1,
                 CHR_CR, CHR_LF, CHR_ZERO, CHR_ZERO,
                 CHR_CR, CHR_LF, CHR_ZERO, CHR_FOUR, CHR_UP_A - 8'd1,
                 CHR_CR, CHR_LF, CHR_CR,      // hunt mismatch on a CR
                 CHR_LF, CHR_ZERO, CHR_ONE, CHR_UP_Z + 8'd1,
                 CHR_CR, CHR_LF, CHR_ZERO, CHR_ONE + 8'd1, CHR_LO_A - 8'd1,
                 CHR_CR, CHR_LF, CHR_ZERO, CHR_ONE + 8'd2, CHR_LO_Z + 8'd1});
    send_record(3'd4, CHR_UP_A + 8'd1, PAY_RANDOM, CHR_ONE);
    // strict mismatch late in the header, CR repeated at the LF position
    send_bytes('{CHR_CR, CHR_LF, CHR_ZERO, CHR_ONE, 8'h00, CHR_CR, CHR_CR});
    send_record(3'd1, CHR_SPACE, PAY_RANDOM, CHR_ONE);
  endtask

  // Stylus setting: off and on, and changed between header and 24th payload byte
  task automatic test_stylus_setting();
    drain();
    write_stylus(1'b0);
    send_record(3'd1, CHR_LO_Z - 8'd2, PAY_RANDOM, CHR_ONE);
    send_header(3'd1, CHR_SPACE);
    send_payload(10, PAY_RANDOM);
    drain();
    write_stylus(1'b1);
    send_payload(PAYLOAD_LEN - 10, PAY_RANDOM);
    send_byte(CHR_ONE);
    send_byte(CHR_ONE);
    send_header(3'd1, CHR_UP_A);
    send_payload(10, PAY_RANDOM);
    drain();
    write_stylus(1'b0);
    send_payload(PAYLOAD_LEN - 10, PAY_RANDOM);
    drain();
    write_stylus(1'b1);
  endtask

  // Long output stall while the sender keeps pushing: input must back up
  task automatic test_output_stall();
    drain();
    hold_cycles = 300;
    repeat (5) send_record(3'($urandom_range(1, 4)), rand_filler(), PAY_RANDOM, CHR_ONE);
    drain();
  endtask

  // Mostly well-formed records with random content, the rest broken headers and noise
  task automatic test_random_stream(input int n_bytes);
    int start;
    int kind;
    int k;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        k = $urandom_range(19);
        send_record(3'($urandom_range(1, 4)), rand_filler(),
                    (k == 0) ? PAY_ZEROS : (k == 1) ? PAY_ONES : PAY_RANDOM,
                    $urandom_range(1) ? CHR_ONE : 8'($urandom));
      end else if (kind < 88) begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++)
          send_byte(header_char(i, 3'($urandom_range(1, 4)), rand_filler()));
        send_byte(noise_char());
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(noise_char());
      end
    end
  endtask

  task automatic run_random_phase(input int src_pct, input int sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    test_random_stream(155);
    drain();
    write_stylus(~stylus_on);
    test_random_stream(155);
    drain();
    write_stylus(~stylus_on);
  endtask

  initial begin
    foreach (words[i]) words[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_clean_records();
    test_header_resync();
    test_stylus_setting();
    test_output_stall();
    run_random_phase(29, 48);
    run_random_phase(48, 29);
    run_random_phase(0, 0);
    drain();

    $display("Covered %0d bytes and %0d records: %0d after a resync, %0d with stylus bytes",
             bytes_sent, rec_count, lost_count, btn_count);
    $display("(%0d pressed); stylus on and off, mid-record change, long output stall.",
             pressed_count);
    if (errors == 0 && pending_records.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
